// ----- rtl/first_substring_match_finder_defines.svh -----
// Assertion macros shared by the substring match finder RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef FIRST_SUBSTRING_MATCH_FINDER_DEFINES_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FSMF_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("fsmf: property violated");
// expression must never be true outside reset
`define FSMF_NEVER(lbl, clk_s, rst_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) \
        else $error("fsmf: forbidden condition seen");
`else
`define FSMF_ASSERT(lbl, clk_s, rst_s, prop)
`define FSMF_NEVER(lbl, clk_s, rst_s, expr)
`endif
`endif

// ----- rtl/fsmf_pkg.sv -----
// Package for the substring match finder: sizes, item codes, control struct
// and the pattern length clamp. No dependencies.
package fsmf_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 32;
    localparam int CFG_W       = 7;

    // item kinds carried in the action field
    localparam logic ACT_PATTERN = 1'b0;
    localparam logic ACT_TEXT    = 1'b1;

    localparam logic [POS_W-1:0] SEEN_MAX = '1;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [POS_W-1:0]  pos_t;

    // control from the item stage to the compare array
    typedef struct packed {
        logic  pat_we;
        idx_t  pat_idx;
        logic  shift_en;
        byte_t data;
    } fsmf_ctrl_t;

    // zero length behaves as one, oversize lengths as the full window
    function automatic len_t clamp_len(logic [CFG_W-1:0] value);
        len_t result;
        if (value == '0)
        begin
            result = len_t'(1);
        end
        else if (int'(value) > PATTERN_MAX)
        begin
            result = len_t'(PATTERN_MAX);
        end
        else
        begin
            result = len_t'(value);
        end
        return result;
    endfunction

endpackage

// ----- rtl/fsmf_match_array.sv -----
// Pattern byte cells, text window shift line and the parallel compare.
// Depends on fsmf_pkg.
module fsmf_match_array (
    input  logic               clk,
    input  fsmf_pkg::fsmf_ctrl_t ctrl,
    input  fsmf_pkg::len_t     len,
    output logic               hit
);
    import fsmf_pkg::*;

    byte_t pat_reg [PATTERN_MAX];
    byte_t win_reg [PATTERN_MAX];
    byte_t win_next [PATTERN_MAX];

    logic [PATTERN_MAX*BYTE_W-1:0] win_flat;
    logic [PATTERN_MAX*BYTE_W-1:0] aligned;
    idx_t                          shamt;
    logic [PATTERN_MAX-1:0]        lane_ok;

    // window after shifting in the new byte, newest at the top entry
    genvar i;
    generate
        for (i = 0; i < PATTERN_MAX; i++)
        begin : g_win
            if (i == PATTERN_MAX - 1)
            begin : g_top
                assign win_next[i] = ctrl.data;
            end
            else
            begin : g_mid
                assign win_next[i] = win_reg[i + 1];
            end
            assign win_flat[i*BYTE_W +: BYTE_W] = win_next[i];
        end
    endgenerate

    // pattern cells and window line hold payload only
    always_ff @(posedge clk)
    begin
        if (ctrl.pat_we)
        begin
            pat_reg[ctrl.pat_idx] <= ctrl.data;
        end
        if (ctrl.shift_en)
        begin
            win_reg <= win_next;
        end
    end

    // bring the newest len bytes down to lane 0
    assign shamt   = idx_t'(len_t'(PATTERN_MAX) - len);
    assign aligned = win_flat >> {shamt, 3'b000};

    // each lane compares one pattern byte; lanes past len always agree
    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_lane
            assign lane_ok[k] = (aligned[k*BYTE_W +: BYTE_W] == pat_reg[k])
                                || (len_t'(k) >= len);
        end
    endgenerate

    assign hit = &lane_ok;

endmodule

// ----- rtl/first_substring_match_finder.sv -----
// Top level of the substring match finder: item stage, run bookkeeping,
// result register. Depends on fsmf_pkg, fsmf_match_array and the defines header.
//
// Usage:
//   s_axis carries items. tuser[0] is action (0 loads a pattern byte at
//   pattern_index, 1 presents a text byte), tuser[1] is first_of_text and
//   tlast is last_of_text. A text run yields exactly one result on m_axis:
//   the first match (found=1, start offset in tdata) or found=0 with
//   offset 0 at the last byte. Later bytes of the run are silent.
//   cfg writes pattern_length (0 acts as 1, above 64 acts as 64); cfg_ready
//   is always high. Write it only while no item is in flight.
// Flow and throughput:
//   An item enters the input register on acceptance, is compared against
//   the newest pattern_length bytes of the 64-byte window and, if it
//   closes a run, lands in the result register, which drives m_axis_tvalid.
//   One item per cycle is sustained while m_axis does not stall a held result.
// Reset clears the pipeline valids, the run counters and sets the length to
//   one; pattern bytes are undefined until loaded. When m_axis stalls the
//   result holds, one more item waits in the input register, then
//   s_axis_tready drops.
`include "first_substring_match_finder_defines.svh"

module first_substring_match_finder (
    input  logic        clk,
    input  logic        rst_n,
    // config: pattern_length
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fsmf_pkg::CFG_W-1:0] cfg_data,
    // tdata: pattern_index [5:0], data_byte [13:6], zero [15:14]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // tuser: action [0], first_of_text [1]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: match_position [31:0]
    output logic [31:0] m_axis_tdata,
    // tuser: found [0]
    output logic [0:0]  m_axis_tuser
);
    import fsmf_pkg::*;

    len_t       eff_len_reg;
    logic       s1_valid_reg;
    logic       s1_action_reg;
    idx_t       s1_idx_reg;
    byte_t      s1_data_reg;
    logic       s1_first_reg;
    logic       s1_last_reg;
    pos_t       seen_reg;
    pos_t       seen_next;
    logic       done_reg;
    logic       done_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       found_reg;
    pos_t       pos_reg;

    logic       accept;
    logic       adv;
    logic       is_text;
    pos_t       base_seen;
    logic       base_done;
    logic       long_enough;
    logic       hit;
    logic       found_now;
    logic       emit;
    logic       load_result;
    fsmf_ctrl_t ctrl;

    // config register, stored already clamped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_len_reg <= len_t'(1);
        end
        else if (cfg_valid)
        begin
            eff_len_reg <= clamp_len(cfg_data);
        end
    end

    // input register handshake
    assign adv           = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= s_axis_tuser[0];
            s1_first_reg  <= s_axis_tuser[1];
            s1_idx_reg    <= s_axis_tdata[IDX_W-1:0];
            s1_data_reg   <= s_axis_tdata[IDX_W +: BYTE_W];
            s1_last_reg   <= s_axis_tlast;
        end
    end

    // drive the compare array
    assign is_text       = (s1_action_reg == ACT_TEXT);
    assign ctrl.pat_we   = adv && (s1_action_reg == ACT_PATTERN);
    assign ctrl.pat_idx  = s1_idx_reg;
    assign ctrl.shift_en = adv && is_text;
    assign ctrl.data     = s1_data_reg;

    fsmf_match_array u_match (
        .clk  (clk),
        .ctrl (ctrl),
        .len  (eff_len_reg),
        .hit  (hit)
    );

    // run bookkeeping: first byte restarts, count saturates
    always_comb
    begin
        base_seen   = s1_first_reg ? '0 : seen_reg;
        base_done   = s1_first_reg ? 1'b0 : done_reg;
        seen_next   = (base_seen == SEEN_MAX) ? base_seen : base_seen + pos_t'(1);
        long_enough = (seen_next >= pos_t'(eff_len_reg));
        found_now   = !base_done && long_enough && hit;
        emit        = found_now || (!base_done && s1_last_reg);
        done_next   = base_done || emit;
        load_result = adv && is_text && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (adv && is_text)
        begin
            seen_reg <= seen_next;
            done_reg <= done_next;
        end
    end

    // result register
    always_comb
    begin
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            found_reg <= found_now;
            pos_reg   <= found_now ? (seen_next - pos_t'(eff_len_reg)) : '0;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = pos_reg;
    assign m_axis_tuser[0] = found_reg;

    // checks
    `FSMF_ASSERT(a_notfound_pos_zero, clk, rst_n,
        (out_valid_reg && !found_reg) |-> (pos_reg == '0))
    `FSMF_ASSERT(a_found_pos_seen, clk, rst_n,
        (out_valid_reg && found_reg) |->
        ((33'(pos_reg) + 33'(eff_len_reg)) == 33'(seen_reg)))
    `FSMF_ASSERT(a_result_closes_run, clk, rst_n, load_result |=> done_reg)
    `FSMF_ASSERT(a_stall_only_when_full, clk, rst_n,
        !s_axis_tready |-> (s1_valid_reg && out_valid_reg && !m_axis_tready))
    `FSMF_NEVER(a_len_in_range, clk, rst_n,
        (eff_len_reg == '0) || (eff_len_reg > len_t'(PATTERN_MAX)))

endmodule

// ----- sim/tb.sv -----
// Testbench for first_substring_match_finder: a directed table scored against its listed results
// or the in-bench search model, then random pattern loads and text runs scored against that model.
// Depends on fsmf_pkg and the RTL top level only.
module tb;
    import fsmf_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 120;
    localparam int NUM_PHASES   = 13;
    localparam int CALM_PHASE   = 2;
    localparam int HOLD_PHASE   = 10;
    localparam int HOLD_CYCLES  = 150;

    typedef enum logic [1:0] {ROW_PAT, ROW_TXT, ROW_CFG} row_kind_e;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_HIT, EXP_MISS} row_exp_e;

    typedef struct {
        logic  action;
        idx_t  idx;
        byte_t data;
        logic  first_flag;
        logic  last_flag;
    } search_item_t;

    typedef struct {
        logic found;
        pos_t pos;
    } match_t;

    typedef struct {
        row_kind_e kind;
        idx_t      idx;
        byte_t     data;
        logic      first_flag;
        logic      last_flag;
        row_exp_e  exp;
        pos_t      pos;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [15:0]      s_axis_tdata;
    logic [1:0]       s_axis_tuser;
    logic             s_axis_tlast;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [31:0]      m_axis_tdata;
    logic [0:0]       m_axis_tuser;

    // search model state
    byte_t            pat_mirror [PATTERN_MAX];
    byte_t            win_mirror [PATTERN_MAX];
    pos_t             seen_count;
    logic             run_closed;
    logic [CFG_W-1:0] cur_len;

    match_t pending_matches [$];
    int     errors = 0;
    int     cycle_count = 0;
    bit     calm_on = 1'b0;
    bit     pressure_on = 1'b0;

    always #5 clk = ~clk;

    first_substring_match_finder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // pattern_index [5:0], data_byte [13:6]
        .s_axis_tuser  (s_axis_tuser),     // action [0], first_of_text [1]
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),     // match_position [31:0]
        .m_axis_tuser  (m_axis_tuser)      // found [0]
    );

    // length in use: zero acts as one, oversize as the full window
    function automatic int active_len();
        if (cur_len == '0)
        begin
            return 1;
        end
        else if (int'(cur_len) > PATTERN_MAX)
        begin
            return PATTERN_MAX;
        end
        return int'(cur_len);
    endfunction

    // advance the search model by one item
    task automatic predict_search(input search_item_t it, output bit emits,
                                  output match_t res);
        int len;
        bit same;
        emits     = 1'b0;
        res.found = 1'b0;
        res.pos   = '0;
        if (it.action == ACT_PATTERN)
        begin
            pat_mirror[it.idx] = it.data;
        end
        else
        begin
            if (it.first_flag)
            begin
                seen_count = '0;
                run_closed = 1'b0;
            end
            for (int k = 0; k < PATTERN_MAX - 1; k++)
                win_mirror[k] = win_mirror[k+1];
            win_mirror[PATTERN_MAX-1] = it.data;
            if (seen_count != SEEN_MAX)
                seen_count = seen_count + 1;
            if (!run_closed)
            begin
                len  = active_len();
                same = 1'b1;
                for (int k = 0; k < len; k++)
                    if (win_mirror[PATTERN_MAX - len + k] != pat_mirror[k])
                        same = 1'b0;
                if (seen_count >= pos_t'(len) && same)
                begin
                    run_closed = 1'b1;
                    emits      = 1'b1;
                    res.found  = 1'b1;
                    res.pos    = seen_count - pos_t'(len);
                end
                else if (it.last_flag)
                begin
                    run_closed = 1'b1;
                    emits      = 1'b1;
                end
            end
        end
    endtask

    // present one item, wait for acceptance, return the model's outcome
    task automatic send_item(input search_item_t it, output bit emits, output match_t res);
        int gap;
        gap = 0;
        if (!calm_on && !pressure_on && $urandom_range(0, 99) < 20)
            gap = $urandom_range(1, 2);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.data, it.idx};
        s_axis_tuser  <= {it.first_flag, it.action};
        s_axis_tlast  <= it.last_flag;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_search(it, emits, res);
    endtask

    task automatic send_predicted(input search_item_t it);
        bit     emits;
        match_t res;
        send_item(it, emits, res);
        if (emits)
            pending_matches.push_back(res);
    endtask

    // stop offering, let every expected result arrive, then let the pipe drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_pattern_length(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_len = value;
    endtask

    function automatic dir_row_t mk_row(row_kind_e kind, int idx, int data, bit f, bit l,
                                        row_exp_e exp, int pos);
        dir_row_t row;
        row.kind       = kind;
        row.idx        = idx_t'(idx);
        row.data       = byte_t'(data);
        row.first_flag = f;
        row.last_flag  = l;
        row.exp        = exp;
        row.pos        = pos_t'(pos);
        return row;
    endfunction

    // stimulus
    initial
    begin
        dir_row_t         dir_tab [$];
        dir_row_t         row;
        search_item_t     it;
        match_t           res;
        bit               emits;
        bit               embed;
        bit               narrow;
        logic [CFG_W-1:0] setting;
        int               count;
        int               r;
        int               len;
        int               run_len;
        int               off;
        int               nb;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        foreach (pat_mirror[k])
            pat_mirror[k] = '0;
        foreach (win_mirror[k])
            win_mirror[k] = '0;
        seen_count = '0;
        run_closed = 1'b0;
        cur_len    = CFG_W'(1);

        // length one after reset
        dir_tab.push_back(mk_row(ROW_PAT, 0, 8'h41, 0, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h00, 1, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h41, 0, 0, EXP_HIT, 1));
        // bytes after a result stay silent
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h41, 0, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h41, 0, 1, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'hFF, 1, 1, EXP_MISS, 0));
        // pattern writes ignore the run flags
        dir_tab.push_back(mk_row(ROW_PAT, 63, 8'hFF, 1, 1, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_PAT, 0, 8'hFF, 1, 1, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 63, 8'hFF, 1, 1, EXP_HIT, 0));
        // zero length acts as one
        dir_tab.push_back(mk_row(ROW_CFG, 0, 0, 0, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h00, 1, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'hFF, 0, 1, EXP_HIT, 1));
        // three-byte pattern FF 12 34
        dir_tab.push_back(mk_row(ROW_PAT, 1, 8'h12, 0, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_PAT, 2, 8'h34, 0, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_CFG, 0, 3, 0, 0, EXP_NONE, 0));
        // text shorter than the pattern
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'hFF, 1, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h12, 0, 1, EXP_MISS, 0));
        // match ending on the last byte is the only result
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h00, 1, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'hFF, 0, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h12, 0, 0, EXP_NONE, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h34, 0, 1, EXP_HIT, 1));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h34, 0, 0, EXP_NONE, 0));
        // new run: old window bytes must not count toward a match
        dir_tab.push_back(mk_row(ROW_TXT, 21, 8'hFF, 1, 0, EXP_MODEL, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 42, 8'h12, 0, 0, EXP_MODEL, 0));
        dir_tab.push_back(mk_row(ROW_TXT, 0, 8'h34, 0, 0, EXP_MODEL, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG)
            begin
                write_pattern_length(row.data[CFG_W-1:0]);
            end
            else
            begin
                it = '{(row.kind == ROW_TXT) ? ACT_TEXT : ACT_PATTERN, row.idx, row.data,
                       row.first_flag, row.last_flag};
                send_item(it, emits, res);
                case (row.exp)
                    EXP_MODEL: if (emits) pending_matches.push_back(res);
                    EXP_HIT:   pending_matches.push_back('{1'b1, row.pos});
                    EXP_MISS:  pending_matches.push_back('{1'b0, pos_t'(0)});
                    default:   ;
                endcase
            end
        end

        // fill the whole pattern store before any longer length is used
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            it = '{ACT_PATTERN, idx_t'(k), byte_t'($urandom_range(0, 255)),
                   1'($urandom), 1'($urandom)};
            send_predicted(it);
        end

        // random phases, one length setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       setting = 7'd1;
                1:       setting = 7'd64;
                2:       setting = 7'd0;
                3:       setting = 7'd127;
                4:       setting = 7'd2;
                5:       setting = 7'd5;
                6:       setting = 7'd65;
                7:       setting = 7'd3;
                8:       setting = 7'd16;
                9:       setting = 7'd8;
                10:      setting = 7'd1;
                11:      setting = 7'd33;
                default: setting = 7'd4;
            endcase
            write_pattern_length(setting);
            calm_on     = (p == CALM_PHASE);
            pressure_on = (p == HOLD_PHASE);
            narrow      = pressure_on ? 1'b1 : 1'($urandom);
            len         = active_len();
            count       = 0;
            while (count < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    // stray pattern rewrite, may land mid-run
                    it = '{ACT_PATTERN, idx_t'($urandom_range(0, 63)),
                           byte_t'($urandom_range(0, 255)), 1'($urandom), 1'($urandom)};
                    send_predicted(it);
                    count++;
                end
                else if (r < 15)
                begin
                    // broken run: random flags
                    nb = $urandom_range(1, 4);
                    for (int j = 0; j < nb; j++)
                    begin
                        it = '{ACT_TEXT, idx_t'($urandom_range(0, 63)),
                               byte_t'($urandom_range(0, 255)),
                               1'($urandom), 1'($urandom)};
                        send_predicted(it);
                        count++;
                    end
                end
                else
                begin
                    // well-formed run, often with the pattern planted in it
                    run_len = $urandom_range(1, len + 12);
                    embed   = (run_len >= len) && ($urandom_range(0, 99) < 60);
                    off     = embed ? $urandom_range(0, run_len - len) : 0;
                    for (int j = 0; j < run_len; j++)
                    begin
                        it.action     = ACT_TEXT;
                        it.idx        = idx_t'($urandom_range(0, 63));
                        it.first_flag = (j == 0);
                        it.last_flag  = (j == run_len - 1);
                        if (embed && j >= off && j < off + len)
                            it.data = pat_mirror[j - off];
                        else if (narrow && $urandom_range(0, 1) == 1)
                            it.data = pat_mirror[$urandom_range(0, len - 1)];
                        else
                            it.data = byte_t'($urandom_range(0, 255));
                        send_predicted(it);
                        count++;
                    end
                end
            end
            calm_on     = 1'b0;
            pressure_on = 1'b0;
        end

        wait_idle();
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // result receiver: random stalls, a calm stretch, one long hold-off
    initial
    begin
        int hold_left;
        bit held;
        hold_left     = 0;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_on && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (calm_on)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("unexpected result: found %0d, match_position %0d",
                       m_axis_tuser[0], m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (m_axis_tuser[0] !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata !== want.pos)
                begin
                    $error("match_position: expected %0d, actual %0d", want.pos, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
